[rtl/palci_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color index allocator: shared definitions
// Sizes of the palette and the recent-color cache, the split of the palette
// into search cells, and the types passed between the modules.
// ----------------------------------------------------------------------------
package palci_pkg;

    // Palette and cache sizes.
    localparam int PALETTE_ENTRIES = 256;
    localparam int MRU_WAYS        = 4;

    // Field widths fixed by the interface.
    localparam int COLOR_W = 15;
    localparam int INDEX_W = 8;

    // The palette is split into cells of up to 64 entries each.
    localparam int CELL_ENTRIES = (PALETTE_ENTRIES < 64) ? PALETTE_ENTRIES : 64;
    localparam int NUM_CELLS    = (PALETTE_ENTRIES + CELL_ENTRIES - 1) / CELL_ENTRIES;

    // Counter and pointer widths.
    localparam int CNT_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int WAY_W = (MRU_WAYS > 1) ? $clog2(MRU_WAYS) : 1;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [INDEX_W-1:0] index_t;

    // Highest count of entries in use, and the index returned when full.
    localparam index_t ENTRY_LIMIT    = INDEX_W'(PALETTE_ENTRIES - 1);
    localparam index_t FALLBACK_INDEX = INDEX_W'(1);
    localparam index_t BLACK_INDEX    = INDEX_W'(0);
    localparam color_t BLACK_COLOR    = COLOR_W'(0);

    // Search result handed along the chain of cells.
    typedef struct packed {
        logic   hit;
        index_t index;
    } match_t;

    // Write of one palette entry.
    typedef struct packed {
        logic   en;
        index_t index;
        color_t color;
    } tbl_wr_t;

    // Insertion of one (color, index) pair into the cache.
    typedef struct packed {
        logic   en;
        color_t color;
        index_t index;
    } mru_wr_t;

endpackage

[rtl/palci_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette search cell
// Holds one slice of the palette, compares every used entry of the slice with
// the query color and merges its match into the result from the left neighbor.
// ----------------------------------------------------------------------------
module palci_cell (
    input  logic              aclk,
    input  palci_pkg::index_t cell_base,
    input  palci_pkg::color_t query,
    input  palci_pkg::index_t entries_used,
    input  palci_pkg::tbl_wr_t tbl_wr,
    input  palci_pkg::match_t acc_in,
    output palci_pkg::match_t acc_out
);

    palci_pkg::color_t entry_reg [palci_pkg::CELL_ENTRIES];
    palci_pkg::match_t acc_reg;
    palci_pkg::match_t acc_next;

    // Entry storage: the entry whose palette index matches the write index
    // takes the new color.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < palci_pkg::CELL_ENTRIES; j++) begin
            if (tbl_wr.en && (tbl_wr.index ==
                    palci_pkg::index_t'(cell_base + palci_pkg::INDEX_W'(j)))) begin
                entry_reg[j] <= tbl_wr.color;
            end
        end
    end

    // Compare the query with every used entry. Used entries are unique, so
    // at most one entry of the whole palette matches and an OR merges them.
    always_comb begin
        palci_pkg::index_t g;
        acc_next = acc_in;
        for (int j = 0; j < palci_pkg::CELL_ENTRIES; j++) begin
            g = palci_pkg::index_t'(cell_base + palci_pkg::INDEX_W'(j));
            if ((g != palci_pkg::BLACK_INDEX) && (g < entries_used) &&
                    (entry_reg[j] == query)) begin
                acc_next.hit   = 1'b1;
                acc_next.index = acc_next.index | g;
            end
        end
    end

    // Hand the merged result to the next cell.
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

[rtl/palci_mru.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recent-color cache
// A few (color, index) pairs checked in way order, refilled round robin.
// ----------------------------------------------------------------------------
module palci_mru (
    input  logic              aclk,
    input  logic              aresetn,
    input  palci_pkg::color_t lookup_color,
    output palci_pkg::match_t lookup,
    input  palci_pkg::mru_wr_t mru_wr
);

    palci_pkg::color_t                mru_colors_reg  [palci_pkg::MRU_WAYS];
    palci_pkg::index_t                mru_indices_reg [palci_pkg::MRU_WAYS];
    logic [palci_pkg::WAY_W-1:0]      mru_pointer_reg;
    logic [palci_pkg::WAY_W-1:0]      mru_pointer_next;

    // Lookup: the lowest matching way wins.
    always_comb begin
        lookup = '0;
        for (int i = palci_pkg::MRU_WAYS - 1; i >= 0; i--) begin
            if (mru_colors_reg[i] == lookup_color) begin
                lookup.hit   = 1'b1;
                lookup.index = mru_indices_reg[i];
            end
        end
    end

    // Round-robin pointer advance.
    always_comb begin
        if (mru_pointer_reg == palci_pkg::WAY_W'(palci_pkg::MRU_WAYS - 1)) begin
            mru_pointer_next = '0;
        end else begin
            mru_pointer_next = mru_pointer_reg + palci_pkg::WAY_W'(1);
        end
    end

    // Way storage and pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mru_pointer_reg <= '0;
            for (int i = 0; i < palci_pkg::MRU_WAYS; i++) begin
                mru_colors_reg[i]  <= '0;
                mru_indices_reg[i] <= '0;
            end
        end else if (mru_wr.en) begin
            mru_colors_reg[mru_pointer_reg]  <= mru_wr.color;
            mru_indices_reg[mru_pointer_reg] <= mru_wr.index;
            mru_pointer_reg                  <= mru_pointer_next;
        end
    end

endmodule

[rtl/palette_color_index_allocator.sv]
// Black or a cache hit goes from the lookup straight to the result; a cache
// miss first searches the chain of palette cells, 64 entries a cycle.
// A new color is taken only once the previous result is in the output register.
// Reset: synchronous, active low; palette count returns to 1, cache cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color index allocator
// Maps RGB15 colors to palette indices, appending new ones while room remains.
// ----------------------------------------------------------------------------
module palette_color_index_allocator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [14:0]           s_color,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_index,
    output logic                  m_added,
    output logic [14:0]           m_palette_color,
    output logic                  m_full_res
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    palci_pkg::color_t             color_reg, color_next;
    logic [palci_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    palci_pkg::index_t             entries_used_reg, entries_used_next;

    palci_pkg::index_t             res_index_reg, res_index_next;
    logic                          res_added_reg, res_added_next;
    palci_pkg::color_t             res_pcolor_reg, res_pcolor_next;
    logic                          res_full_reg, res_full_next;

    logic                          m_valid_reg, m_valid_next;
    palci_pkg::index_t             m_index_reg, m_index_next;
    logic                          m_added_reg, m_added_next;
    palci_pkg::color_t             m_pcolor_reg, m_pcolor_next;
    logic                          m_full_reg, m_full_next;

    palci_pkg::match_t             mru_hit;
    palci_pkg::mru_wr_t            mru_wr;
    palci_pkg::tbl_wr_t            tbl_wr;
    palci_pkg::match_t             acc_in    [palci_pkg::NUM_CELLS];
    palci_pkg::match_t             acc_chain [palci_pkg::NUM_CELLS];
    palci_pkg::match_t             search_res;

    // Recent-color cache.
    palci_mru u_mru (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lookup_color (color_reg),
        .lookup       (mru_hit),
        .mru_wr       (mru_wr)
    );

    // Chain of palette cells; each merges its match into its neighbor's result.
    assign acc_in[0] = '0;
    for (genvar k = 0; k < palci_pkg::NUM_CELLS; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign acc_in[k] = acc_chain[k-1];
        end
        palci_cell u_cell (
            .aclk         (aclk),
            .cell_base    (palci_pkg::INDEX_W'(k * palci_pkg::CELL_ENTRIES)),
            .query        (color_reg),
            .entries_used (entries_used_reg),
            .tbl_wr       (tbl_wr),
            .acc_in       (acc_in[k]),
            .acc_out      (acc_chain[k])
        );
    end

    assign search_res = acc_chain[palci_pkg::NUM_CELLS-1];

    // Sequencer: lookup, chain search, palette update and result hand-off.
    always_comb begin
        state_next        = state_reg;
        color_next        = color_reg;
        cnt_next          = cnt_reg;
        entries_used_next = entries_used_reg;
        res_index_next    = res_index_reg;
        res_added_next    = res_added_reg;
        res_pcolor_next   = res_pcolor_reg;
        res_full_next     = res_full_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_index_next      = m_index_reg;
        m_added_next      = m_added_reg;
        m_pcolor_next     = m_pcolor_reg;
        m_full_next       = m_full_reg;
        mru_wr            = '0;
        tbl_wr            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    color_next = s_color;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                res_index_next  = palci_pkg::BLACK_INDEX;
                res_added_next  = 1'b0;
                res_pcolor_next = palci_pkg::BLACK_COLOR;
                res_full_next   = 1'b0;
                cnt_next        = '0;
                if (color_reg == palci_pkg::BLACK_COLOR) begin
                    state_next = ST_EMIT;
                end else if (mru_hit.hit) begin
                    res_index_next = mru_hit.index;
                    state_next     = ST_EMIT;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cnt_reg == palci_pkg::CNT_W'(palci_pkg::NUM_CELLS - 1)) begin
                    state_next = ST_EMIT;
                    if (search_res.hit) begin
                        // Found in the palette: remember it in the cache.
                        res_index_next = search_res.index;
                        mru_wr         = '{en: 1'b1, color: color_reg,
                                           index: search_res.index};
                    end else if (entries_used_reg < palci_pkg::ENTRY_LIMIT) begin
                        // Append a new entry at the end of the palette.
                        res_index_next    = entries_used_reg;
                        res_added_next    = 1'b1;
                        res_pcolor_next   = color_reg;
                        tbl_wr            = '{en: 1'b1, index: entries_used_reg,
                                              color: color_reg};
                        mru_wr            = '{en: 1'b1, color: color_reg,
                                              index: entries_used_reg};
                        entries_used_next = entries_used_reg + palci_pkg::INDEX_W'(1);
                    end else begin
                        // Palette full: fall back to the first color entry.
                        res_index_next = palci_pkg::FALLBACK_INDEX;
                        res_full_next  = 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + palci_pkg::CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_index_next  = res_index_reg;
                    m_added_next  = res_added_reg;
                    m_pcolor_next = res_pcolor_reg;
                    m_full_next   = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            entries_used_reg <= palci_pkg::INDEX_W'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            entries_used_reg <= entries_used_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        color_reg      <= color_next;
        res_index_reg  <= res_index_next;
        res_added_reg  <= res_added_next;
        res_pcolor_reg <= res_pcolor_next;
        res_full_reg   <= res_full_next;
        m_index_reg    <= m_index_next;
        m_added_reg    <= m_added_next;
        m_pcolor_reg   <= m_pcolor_next;
        m_full_reg     <= m_full_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_index         = m_index_reg;
    assign m_added         = m_added_reg;
    assign m_palette_color = m_pcolor_reg;
    assign m_full_res      = m_full_reg;

endmodule
